### src/a85_pkg.sv
// shared types, constants and sequencer states for the ascii85 stream encoder
// no dependencies; imported by every module of the block
package a85_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_MUL,
    ST_DIV_REM,
    ST_CHR,
    ST_NL,
    ST_TRAIL_NL,
    ST_TILDE,
    ST_GT,
    ST_END_NL
  } st_e;

  localparam logic [7:0]  CharBang   = 8'h21;
  localparam logic [7:0]  CharZ      = 8'h7A;
  localparam logic [7:0]  CharTilde  = 8'h7E;
  localparam logic [7:0]  CharGt     = 8'h3E;
  localparam logic [7:0]  CharNl     = 8'h0A;

  localparam logic [31:0] Radix      = 32'd85;
  localparam logic [31:0] DivMagic   = 32'hC0C0C0C1;
  localparam int          DivShift   = 38;
  localparam int          QuotW      = 64 - DivShift;
  localparam int          DigitW     = 7;
  localparam int          NumDigits  = 5;

  localparam logic [7:0]  WidthMin   = 8'd10;
  localparam logic [7:0]  WidthMax   = 8'd200;
  localparam logic [7:0]  WidthReset = 8'd72;

endpackage

### src/a85_div85.sv
// shared divide-by-85 unit: registered reciprocal multiply, then remainder
// depends on a85_pkg
module a85_div85 import a85_pkg::*; (
  input  logic                clk_i,
  input  logic                load_i,
  input  logic [31:0]         num_i,
  output logic [QuotW-1:0]    quot_o,
  output logic [DigitW-1:0]   rem_o
);

  logic [31:0]      num_q;
  logic [QuotW-1:0] quot_q;
  logic [63:0]      prod_d;
  logic [31:0]      q85;

  assign prod_d = 64'(num_i) * 64'(DivMagic);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q  <= num_i;
      quot_q <= prod_d[63:DivShift];
    end
  end

  assign q85    = 32'(quot_q) * Radix;
  assign quot_o = quot_q;
  assign rem_o  = DigitW'(num_q - q85);

endmodule

### src/ascii85_stream_encoder_top.sv
// top level of the ascii85 stream encoder: input group packing, digit sequencer,
// line position tracking and output register; depends on a85_pkg and a85_div85
// a full nonzero group is accepted, then its digits are extracted by 5 passes of the
// divide-by-85 unit (multiply state, then remainder state), then 1 char/cycle
// throughput: one character per cycle while out_ready_i is high; a 'z' group skips the
// divide passes, a partial byte emits nothing, and end of stream adds the trailer; async reset
module ascii85_stream_encoder_top import a85_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i
);

  st_e state_q, state_d;

  logic [31:0] grp_q;
  logic [1:0]  cnt_q;
  logic [7:0]  pos_q;
  logic [7:0]  width_q;
  logic [31:0] w_q;
  logic [2:0]  ndig_q, k_q, e_idx_q;
  logic        zero_q, eos_q;
  logic [DigitW-1:0] dig_q [NumDigits];
  logic        out_valid_q;
  out_t        out_q;

  logic        in_acc;
  logic [4:0]  shamt;
  logic [31:0] merged;
  logic        full, zero_grp;
  logic [1:0]  cnt_after;
  logic [2:0]  ndig_n;

  logic        more_dig, wrap, trail_need, can_push;
  logic        emit_req, push, adv, div_load;
  out_t        emit;
  logic [QuotW-1:0]  quot;
  logic [DigitW-1:0] rem;

  a85_div85 u_div (
    .clk_i  (clk_i),
    .load_i (div_load),
    .num_i  (w_q),
    .quot_o (quot),
    .rem_o  (rem)
  );

  // input transaction decode
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign shamt      = {2'(2'd3 - cnt_q), 3'b000};
  assign merged     = in_data_i.has_byte ? (grp_q | (32'(in_data_i.data_byte) << shamt))
                                         : grp_q;
  assign full       = in_data_i.has_byte && (cnt_q == 2'd3);
  assign zero_grp   = full && (merged == 32'd0);
  assign cnt_after  = in_data_i.has_byte ? 2'(cnt_q + 2'd1) : cnt_q;

  always_comb begin
    if (zero_grp) begin
      ndig_n = 3'd1;
    end else if (full) begin
      ndig_n = 3'(NumDigits);
    end else if (in_data_i.end_of_stream && (cnt_after != 2'd0)) begin
      ndig_n = 3'({1'b0, cnt_after} + 3'd1);
    end else begin
      ndig_n = 3'd0;
    end
  end

  assign more_dig   = (3'(e_idx_q + 3'd1) < ndig_q);
  assign wrap       = (pos_q >= width_q);
  assign trail_need = ({1'b0, pos_q} + 9'd2) > {1'b0, width_q};
  assign can_push   = !out_valid_q || out_ready_i;

  // output decode
  always_comb begin
    emit_req      = 1'b0;
    div_load      = 1'b0;
    emit.out_char = CharNl;
    emit.last     = 1'b0;
    case (state_q)
      ST_DIV_MUL: begin
        div_load = 1'b1;
      end
      ST_CHR: begin
        emit_req      = 1'b1;
        emit.out_char = zero_q ? CharZ : ({1'b0, dig_q[e_idx_q]} + CharBang);
        emit.last     = !wrap && !more_dig && !eos_q;
      end
      ST_NL: begin
        emit_req  = 1'b1;
        emit.last = !more_dig && !eos_q;
      end
      ST_TRAIL_NL: begin
        emit_req = trail_need;
      end
      ST_TILDE: begin
        emit_req      = 1'b1;
        emit.out_char = CharTilde;
      end
      ST_GT: begin
        emit_req      = 1'b1;
        emit.out_char = CharGt;
      end
      ST_END_NL: begin
        emit_req  = 1'b1;
        emit.last = 1'b1;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  assign push = emit_req && can_push;
  assign adv  = !emit_req || can_push;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (ndig_n != 3'd0) begin
            state_d = zero_grp ? ST_CHR : ST_DIV_MUL;
          end else if (in_data_i.end_of_stream) begin
            state_d = ST_TRAIL_NL;
          end
        end
      end
      ST_DIV_MUL: state_d = ST_DIV_REM;
      ST_DIV_REM: state_d = (k_q == 3'(NumDigits - 1)) ? ST_CHR : ST_DIV_MUL;
      ST_CHR: begin
        if (push) begin
          if (wrap) begin
            state_d = ST_NL;
          end else if (more_dig) begin
            state_d = ST_CHR;
          end else begin
            state_d = eos_q ? ST_TRAIL_NL : ST_IDLE;
          end
        end
      end
      ST_NL: begin
        if (push) begin
          if (more_dig) begin
            state_d = ST_CHR;
          end else begin
            state_d = eos_q ? ST_TRAIL_NL : ST_IDLE;
          end
        end
      end
      ST_TRAIL_NL: if (adv) state_d = ST_TILDE;
      ST_TILDE:    if (push) state_d = ST_GT;
      ST_GT:       if (push) state_d = ST_END_NL;
      ST_END_NL:   if (push) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grp_q       <= 32'd0;
      cnt_q       <= 2'd0;
      pos_q       <= 8'd0;
      width_q     <= WidthReset;
      ndig_q      <= 3'd0;
      zero_q      <= 1'b0;
      eos_q       <= 1'b0;
      k_q         <= 3'd0;
      e_idx_q     <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        width_q <= (cfg_data_i inside {[WidthMin:WidthMax]}) ? cfg_data_i : WidthReset;
      end
      if (in_acc) begin
        ndig_q  <= ndig_n;
        zero_q  <= zero_grp;
        eos_q   <= in_data_i.end_of_stream;
        k_q     <= 3'd0;
        e_idx_q <= 3'd0;
        if (full || in_data_i.end_of_stream) begin
          grp_q <= 32'd0;
          cnt_q <= 2'd0;
        end else begin
          grp_q <= merged;
          cnt_q <= cnt_after;
        end
      end
      if (state_q == ST_DIV_REM) begin
        k_q <= 3'(k_q + 3'd1);
      end
      if (push && (state_q == ST_CHR)) begin
        pos_q <= wrap ? 8'd0 : 8'(pos_q + 8'd1);
        if (!wrap && more_dig) begin
          e_idx_q <= 3'(e_idx_q + 3'd1);
        end
      end
      if (push && (state_q == ST_NL) && more_dig) begin
        e_idx_q <= 3'(e_idx_q + 3'd1);
      end
      if (push && (state_q == ST_END_NL)) begin
        pos_q <= 8'd0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // digit store, working word and output character register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      w_q <= merged;
    end else if (state_q == ST_DIV_REM) begin
      w_q <= 32'(quot);
      dig_q[3'(NumDigits - 1) - k_q] <= rem;
    end
    if (push) begin
      out_q <= emit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= WidthMax)
    else $error("line position beyond maximum width");

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q >= WidthMin) && (width_q <= WidthMax))
    else $error("line width register out of range");

  a_chr_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHR) |-> (e_idx_q < ndig_q))
    else $error("digit index past digit count");

  a_quiet_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !full && !in_data_i.end_of_stream) |=> (state_q == ST_IDLE))
    else $error("partial byte transaction left the idle state");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (state_q == ST_END_NL)) |=> ((pos_q == 8'd0) && (cnt_q == 2'd0)))
    else $error("trailer did not clear line and group state");

endmodule
